// ===== rtl/hrkd_pkg.sv =====
`default_nettype none
package hrkd_pkg;

	localparam int LEN_BITS_DEF = 16;
	localparam int SIZE_W       = 16;

	localparam logic [7:0] NAL_TYPE_MASK = 8'h7E;
	localparam logic [7:0] FU_TYPE_MASK  = 8'h3F;
	localparam logic [7:0] FU_START_BIT  = 8'h80;

	localparam logic [5:0] TYPE_VPS = 6'd32;
	localparam logic [5:0] TYPE_SPS = 6'd33;
	localparam logic [5:0] TYPE_AP  = 6'd48;
	localparam logic [5:0] TYPE_FU  = 6'd49;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       last_byte;
		logic [1:0] marking_len;
		logic       fm_start;
		logic       fm_end;
		logic       fm_independent;
		logic       fm_discardable;
		logic       fm_base;
		logic [2:0] fm_tid;
		logic [7:0] fm_lid;
		logic [7:0] fm_tl0_index;
	} in_item_t;

	typedef struct packed {
		logic       desc_valid;
		logic       key_frame;
		logic       start_flag;
		logic       end_flag;
		logic       independent_flag;
		logic       discardable_flag;
		logic       base_flag;
		logic [2:0] temporal_id;
		logic [7:0] layer_id;
		logic [7:0] tl0_index;
		logic [1:0] fields_present;
	} out_item_t;

	typedef struct packed {
		logic key_found;
		logic long_enough;
	} parse_res_t;

	function automatic logic [5:0] nal_type(input logic [7:0] b);
		logic [7:0] m;
		m = (b & NAL_TYPE_MASK) >> 1;
		return m[5:0];
	endfunction

	function automatic logic is_param_set(input logic [5:0] t);
		return (t == TYPE_VPS) || (t == TYPE_SPS);
	endfunction

	function automatic logic fu_starts_param_set(input logic [7:0] b);
		logic [7:0] t;
		t = b & FU_TYPE_MASK;
		return ((b & FU_START_BIT) != 8'h00) && is_param_set(t[5:0]);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hevc_rtp_keyframe_detect_top.sv =====
// A descriptor is built from a packet's last byte in the input register and held
// in the result register. Throughput: one payload byte per cycle unless
// result_stall blocks it; a descriptor waits in its own register while the next
// byte is taken into the input register. Reset: arst_n clears the parser to the
// first header byte and empties both stages; payload registers are not reset.
`default_nettype none
module hevc_rtp_keyframe_detect_top
	import hrkd_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     byte_valid,
	output logic          byte_stall,
	input  wire in_item_t byte_item,
	output logic          result_valid,
	input  wire logic     result_stall,
	output out_item_t     result
);

	logic       valid_s1;
	in_item_t   item_s1;
	logic       desc_ready;
	parse_res_t pres;

	assign byte_stall = valid_s1 && !desc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			item_s1 <= byte_item;
		end
	end

	hrkd_parser #(
		.LEN_BITS(LEN_BITS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (valid_s1 && desc_ready),
		.data  (item_s1.payload_byte),
		.last  (item_s1.last_byte),
		.res   (pres)
	);

	hrkd_desc u_desc (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (valid_s1),
		.item        (item_s1),
		.pres        (pres),
		.ready       (desc_ready),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule
`default_nettype wire

// ===== rtl/hrkd_parser.sv =====
`default_nettype none
module hrkd_parser
	import hrkd_pkg::*;
#(
	parameter int LEN_BITS = LEN_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data,
	input  wire logic       last,
	output parse_res_t      res
);

	localparam logic [2:0] PH_FIRST    = 3'd0;
	localparam logic [2:0] PH_SECOND   = 3'd1;
	localparam logic [2:0] PH_SIZE_HI  = 3'd2;
	localparam logic [2:0] PH_SIZE_LO  = 3'd3;
	localparam logic [2:0] PH_UNIT_HDR = 3'd4;
	localparam logic [2:0] PH_SKIP     = 3'd5;
	localparam logic [2:0] PH_FU_HDR   = 3'd6;
	localparam logic [2:0] PH_IDLE     = 3'd7;

	logic [LEN_BITS-1:0] cnt_q, cnt_d;
	logic [5:0]          type_q, type_d;
	logic [2:0]          phase_q, phase_d;
	logic [SIZE_W-1:0]   size_q, size_d;
	logic [SIZE_W-1:0]   skip_q, skip_d;
	logic                key_q, key_d;

	always_comb begin
		phase_d = phase_q;
		type_d  = type_q;
		size_d  = size_q;
		skip_d  = skip_q;
		key_d   = key_q;
		unique case (phase_q)
			PH_FIRST: begin
				type_d = nal_type(data);
				if (is_param_set(type_d)) begin
					key_d = 1'b1;
				end
				phase_d = PH_SECOND;
			end
			PH_SECOND: begin
				if (key_q) begin
					phase_d = PH_IDLE;
				end else if (type_q == TYPE_AP) begin
					phase_d = PH_SIZE_HI;
				end else if (type_q == TYPE_FU) begin
					phase_d = PH_FU_HDR;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_SIZE_HI: begin
				size_d  = SIZE_W'({data, 8'h00});
				phase_d = PH_SIZE_LO;
			end
			PH_SIZE_LO: begin
				size_d  = {size_q[SIZE_W-1:8], data};
				phase_d = PH_UNIT_HDR;
			end
			PH_UNIT_HDR: begin
				if (is_param_set(nal_type(data))) begin
					key_d   = 1'b1;
					phase_d = PH_IDLE;
				end else if (size_q == '0) begin
					size_d  = SIZE_W'({data, 8'h00});
					phase_d = PH_SIZE_LO;
				end else if (size_q == SIZE_W'(1)) begin
					phase_d = PH_SIZE_HI;
				end else begin
					skip_d  = size_q - SIZE_W'(1);
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_d = skip_q - SIZE_W'(1);
				if (skip_d == '0) begin
					phase_d = PH_SIZE_HI;
				end
			end
			PH_FU_HDR: begin
				if (fu_starts_param_set(data)) begin
					key_d = 1'b1;
				end
				phase_d = PH_IDLE;
			end
			PH_IDLE: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	assign cnt_d = (cnt_q != '1) ? cnt_q + LEN_BITS'(1) : cnt_q;

	assign res.key_found   = key_d;
	assign res.long_enough = cnt_d >= LEN_BITS'(2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			type_q  <= '0;
			phase_q <= PH_FIRST;
			size_q  <= '0;
			skip_q  <= '0;
			key_q   <= 1'b0;
		end else if (step) begin
			if (last) begin
				cnt_q   <= '0;
				type_q  <= '0;
				phase_q <= PH_FIRST;
				size_q  <= '0;
				skip_q  <= '0;
				key_q   <= 1'b0;
			end else begin
				cnt_q   <= cnt_d;
				type_q  <= type_d;
				phase_q <= phase_d;
				size_q  <= size_d;
				skip_q  <= skip_d;
				key_q   <= key_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/hrkd_desc.sv =====
`default_nettype none
module hrkd_desc
	import hrkd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire in_item_t   item,
	input  wire parse_res_t pres,
	output logic            ready,
	output logic            result_valid,
	input  wire logic       result_stall,
	output out_item_t       result
);

	out_item_t desc;
	logic      marked;

	assign ready  = !result_valid || !result_stall;
	assign marked = item.marking_len != 2'd0;

	always_comb begin
		desc = '0;
		if (pres.long_enough) begin
			desc.desc_valid = 1'b1;
			desc.key_frame  = pres.key_found || (marked && item.fm_start && item.fm_independent);
			if (marked) begin
				desc.start_flag       = item.fm_start;
				desc.end_flag         = item.fm_end;
				desc.independent_flag = item.fm_independent;
				desc.discardable_flag = item.fm_discardable;
				desc.base_flag        = item.fm_base;
				desc.temporal_id      = item.fm_tid;
				desc.fields_present   = item.marking_len;
				if (item.marking_len >= 2'd2) begin
					desc.layer_id = item.fm_lid;
				end
				if (item.marking_len == 2'd3) begin
					desc.tl0_index = item.fm_tl0_index;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (ready) begin
			result_valid <= item_valid && item.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && item_valid && item.last_byte) begin
			result <= desc;
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import hrkd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;

	typedef enum logic [2:0] {
		AT_HDR0, AT_HDR1, AT_LEN_HI, AT_LEN_LO, AT_UNIT_HDR, AT_SKIP, AT_FU_HDR, AT_REST
	} walk_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	in_item_t byte_item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_item_t result;

	in_item_t pending_bytes[$];
	logic [7:0] pkt_bytes[$];
	out_item_t descriptors_due[$];

	logic [LEN_BITS_DEF-1:0] rx_count = '0;
	logic [5:0] pkt_type = '0;
	walk_t walk_at = AT_HDR0;
	logic [15:0] unit_len = '0;
	logic [15:0] skip_left = '0;
	logic key_seen = 1'b0;

	int mismatches = 0;
	int bytes_sent = 0;
	int bytes_accepted = 0;
	int short_bytes = 0;
	int total_bytes = 0;
	int idle_cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	logic byte_taken = 1'b0;

	hevc_rtp_keyframe_detect_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	function automatic logic [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	function automatic logic param_set_nal(input logic [5:0] t);
		return (t == TYPE_VPS) || (t == TYPE_SPS);
	endfunction

	function automatic logic [5:0] param_type();
		return ($urandom_range(1) != 0) ? TYPE_SPS : TYPE_VPS;
	endfunction

	function automatic logic [7:0] nal_hdr(input logic [5:0] t);
		logic [7:0] h;
		h = rand_byte();
		h[6:1] = t;
		return h;
	endfunction

	function automatic in_item_t random_marks();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(in_item_t)-1:0];
	endfunction

	task automatic queue_packet(input in_item_t marks);
		in_item_t it;
		for (int k = 0; k < pkt_bytes.size(); k++) begin
			it = marks;
			it.payload_byte = pkt_bytes[k];
			it.last_byte = (k == pkt_bytes.size() - 1);
			pending_bytes.push_back(it);
		end
		pkt_bytes.delete();
	endtask

	task automatic random_packet();
		int kind;
		int sz;
		int keep;
		logic reuse;
		kind = $urandom_range(99);
		if (kind < 25) begin
			pkt_bytes.push_back(nal_hdr(($urandom_range(4) == 0) ? param_type() : 6'($urandom)));
			repeat ($urandom_range(0, 5)) pkt_bytes.push_back(rand_byte());
		end else if (kind < 55) begin
			pkt_bytes.push_back(nal_hdr(TYPE_AP));
			pkt_bytes.push_back(rand_byte());
			reuse = 1'b0;
			repeat ($urandom_range(1, 3)) begin
				sz = $urandom_range(0, 4);
				if (!reuse)
					pkt_bytes.push_back(($urandom_range(9) == 0) ? rand_byte() : 8'h00);
				pkt_bytes.push_back(8'(sz));
				if (sz == 0) begin
					pkt_bytes.push_back(8'($urandom_range(1)));
					reuse = 1'b1;
				end else begin
					pkt_bytes.push_back(nal_hdr(($urandom_range(4) == 0) ? param_type() :
						6'($urandom)));
					repeat (sz - 1) pkt_bytes.push_back(rand_byte());
					reuse = 1'b0;
				end
			end
			if ($urandom_range(3) == 0) begin
				keep = $urandom_range(1, pkt_bytes.size());
				while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
			end
		end else if (kind < 80) begin
			pkt_bytes.push_back(nal_hdr(TYPE_FU));
			pkt_bytes.push_back(rand_byte());
			if ($urandom_range(6) != 0) begin
				pkt_bytes.push_back({($urandom_range(9) < 7), 1'($urandom),
					($urandom_range(1) != 0) ? param_type() : 6'($urandom)});
				repeat ($urandom_range(0, 3)) pkt_bytes.push_back(rand_byte());
			end
		end else begin
			repeat ($urandom_range(1, 6)) pkt_bytes.push_back(rand_byte());
		end
		queue_packet(random_marks());
	endtask

	task automatic track_byte(input in_item_t it);
		logic [7:0] b;
		out_item_t d;
		b = it.payload_byte;
		case (walk_at)
			AT_HDR0: begin
				pkt_type = b[6:1];
				if (param_set_nal(pkt_type))
					key_seen = 1'b1;
				walk_at = AT_HDR1;
			end
			AT_HDR1: begin
				if (key_seen)
					walk_at = AT_REST;
				else if (pkt_type == TYPE_AP)
					walk_at = AT_LEN_HI;
				else if (pkt_type == TYPE_FU)
					walk_at = AT_FU_HDR;
				else
					walk_at = AT_REST;
			end
			AT_LEN_HI: begin
				unit_len = {b, 8'h00};
				walk_at = AT_LEN_LO;
			end
			AT_LEN_LO: begin
				unit_len = {unit_len[15:8], b};
				walk_at = AT_UNIT_HDR;
			end
			AT_UNIT_HDR: begin
				if (param_set_nal(b[6:1])) begin
					key_seen = 1'b1;
					walk_at = AT_REST;
				end else if (unit_len == 16'd0) begin
					unit_len = {b, 8'h00};
					walk_at = AT_LEN_LO;
				end else if (unit_len == 16'd1) begin
					walk_at = AT_LEN_HI;
				end else begin
					skip_left = unit_len - 16'd1;
					walk_at = AT_SKIP;
				end
			end
			AT_SKIP: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 16'd0)
					walk_at = AT_LEN_HI;
			end
			AT_FU_HDR: begin
				if (b[7] && param_set_nal(b[5:0]))
					key_seen = 1'b1;
				walk_at = AT_REST;
			end
			default: walk_at = AT_REST;
		endcase
		if (rx_count != '1)
			rx_count = rx_count + 1'b1;
		if (it.last_byte) begin
			d = '0;
			if (rx_count >= 2) begin
				d.desc_valid = 1'b1;
				d.key_frame = key_seen;
				if (it.marking_len != 2'd0) begin
					d.start_flag = it.fm_start;
					d.end_flag = it.fm_end;
					d.independent_flag = it.fm_independent;
					d.discardable_flag = it.fm_discardable;
					d.base_flag = it.fm_base;
					d.temporal_id = it.fm_tid;
					if (it.marking_len >= 2'd2)
						d.layer_id = it.fm_lid;
					if (it.marking_len == 2'd3)
						d.tl0_index = it.fm_tl0_index;
					d.fields_present = it.marking_len;
					if (it.fm_start && it.fm_independent)
						d.key_frame = 1'b1;
				end
			end
			descriptors_due.push_back(d);
			rx_count = '0;
			pkt_type = '0;
			walk_at = AT_HDR0;
			unit_len = '0;
			skip_left = '0;
			key_seen = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (bytes_sent < short_bytes / 3) begin
				send_idle = 33;
				recv_idle = 55;
			end else if (bytes_sent < 2 * short_bytes / 3) begin
				send_idle = 55;
				recv_idle = 33;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			result_stall <= ($urandom_range(99) < recv_idle);
			if (!byte_valid || byte_taken) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle) begin
					byte_item <= pending_bytes.pop_front();
					byte_valid <= 1'b1;
					bytes_sent++;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		byte_taken = byte_valid && !byte_stall;
		if (arst_n) begin
			idle_cycles++;
			if (byte_valid && !byte_stall) begin
				bytes_accepted++;
				idle_cycles = 0;
				track_byte(byte_item);
			end
			if (result_valid && !result_stall) begin
				idle_cycles = 0;
				if (descriptors_due.size() == 0) begin
					$error("descriptor with none pending");
					mismatches++;
				end else begin
					want = descriptors_due.pop_front();
					check_field("desc_valid", 8'(want.desc_valid), 8'(result.desc_valid));
					check_field("key_frame", 8'(want.key_frame), 8'(result.key_frame));
					check_field("start_flag", 8'(want.start_flag), 8'(result.start_flag));
					check_field("end_flag", 8'(want.end_flag), 8'(result.end_flag));
					check_field("independent_flag", 8'(want.independent_flag),
						8'(result.independent_flag));
					check_field("discardable_flag", 8'(want.discardable_flag),
						8'(result.discardable_flag));
					check_field("base_flag", 8'(want.base_flag), 8'(result.base_flag));
					check_field("temporal_id", 8'(want.temporal_id), 8'(result.temporal_id));
					check_field("layer_id", want.layer_id, result.layer_id);
					check_field("tl0_index", want.tl0_index, result.tl0_index);
					check_field("fields_present", 8'(want.fields_present),
						8'(result.fields_present));
				end
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("hevc_rtp_keyframe_detect_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		in_item_t marks;

		pkt_bytes = {8'h40};
		queue_packet('1);
		pkt_bytes = {8'h40, 8'h01};
		queue_packet('0);
		pkt_bytes = {8'h43, 8'h01};
		queue_packet(random_marks());
		pkt_bytes = {8'h62, 8'h01};
		queue_packet('0);
		pkt_bytes = {8'h62, 8'h01, 8'hA1};
		queue_packet('0);
		pkt_bytes = {8'h62, 8'h01, 8'h21};
		queue_packet('0);
		marks = random_marks();
		marks.marking_len = 2'd2;
		pkt_bytes = {8'h60, 8'h01, 8'h00, 8'h00, 8'h00, 8'h02, 8'h42, 8'h00};
		queue_packet(marks);
		marks = '0;
		marks.marking_len = 2'd1;
		marks.fm_start = 1'b1;
		marks.fm_independent = 1'b1;
		pkt_bytes = {8'h02, 8'h01};
		queue_packet(marks);
		marks = '1;
		marks.marking_len = 2'd2;
		pkt_bytes = {8'hFF, 8'hFF};
		queue_packet(marks);

		while (pending_bytes.size() < 700)
			random_packet();
		short_bytes = pending_bytes.size();
		total_bytes = pending_bytes.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (bytes_accepted != total_bytes) @(negedge clk);
		while (descriptors_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("hevc_rtp_keyframe_detect_top verification clean");
		else
			$display("hevc_rtp_keyframe_detect_top verification failed");
		$finish;
	end

endmodule
